// ===== design/pbel_pkg.sv =====
// package with shared types and constants of the parking brake engage logic
`default_nettype none

package pbel_pkg;

   localparam int SPEED_WIDTH = 16;
   localparam int THR_WIDTH   = 15;
   localparam int ALPHA_WIDTH = 16;
   localparam int COUNT_WIDTH = 8;
   localparam int FILT_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [THR_WIDTH-1:0]   MIN_LINEAR_RESET  = 15'd410;
   localparam logic [THR_WIDTH-1:0]   MIN_ANGULAR_RESET = 15'd410;
   localparam logic [ALPHA_WIDTH-1:0] FILTER_ALPHA_RESET = 16'd3277;
   localparam logic [COUNT_WIDTH-1:0] HOLD_LIMIT_RESET  = 8'd200;
   localparam logic [COUNT_WIDTH-1:0] HOLD_COUNT_RESET  = 8'd51;
   localparam logic [COUNT_WIDTH-1:0] HOLD_JUMP_VALUE   = 8'd254;
   localparam logic [COUNT_WIDTH-1:0] HOLD_COUNT_MAX    = 8'd255;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_LINEAR   = 2'd0,
      CSR_MIN_ANGULAR  = 2'd1,
      CSR_FILTER_ALPHA = 2'd2,
      CSR_HOLD_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THR_WIDTH-1:0]   lin_speed_thr;
      logic [THR_WIDTH-1:0]   ang_speed_thr;
      logic [ALPHA_WIDTH-1:0] filter_alpha;
      logic [COUNT_WIDTH-1:0] hold_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/pbel_if.sv =====
// request and response channel interfaces
`default_nettype none

interface pbel_req_if;
   import pbel_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] goal_linear;
   logic signed [SPEED_WIDTH-1:0] goal_angular;
   logic signed [SPEED_WIDTH-1:0] speed_left;
   logic signed [SPEED_WIDTH-1:0] speed_right;
   logic                          forward_blocked;
   logic                          emergency_stop;

   modport source (output valid, goal_linear, goal_angular, speed_left, speed_right,
                   forward_blocked, emergency_stop, input ready);
   modport sink (input valid, goal_linear, goal_angular, speed_left, speed_right,
                 forward_blocked, emergency_stop, output ready);
endinterface

interface pbel_rsp_if;
   logic valid;
   logic ready;
   logic brake_on;
   logic lock_on;
   logic braking;

   modport source (output valid, brake_on, lock_on, braking, input ready);
   modport sink (input valid, brake_on, lock_on, braking, output ready);
endinterface

`default_nettype wire

// ===== design/pbel_csr.sv =====
// configuration register file
`default_nettype none

module pbel_csr
   import pbel_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]       csr_wdata,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_LINEAR:   cfg_in.lin_speed_thr = csr_wdata[THR_WIDTH-1:0];
            CSR_MIN_ANGULAR:  cfg_in.ang_speed_thr = csr_wdata[THR_WIDTH-1:0];
            CSR_FILTER_ALPHA: cfg_in.filter_alpha  = csr_wdata[ALPHA_WIDTH-1:0];
            CSR_HOLD_LIMIT:   cfg_in.hold_limit    = csr_wdata[COUNT_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lin_speed_thr <= MIN_LINEAR_RESET;
         cfg_ff.ang_speed_thr <= MIN_ANGULAR_RESET;
         cfg_ff.filter_alpha  <= FILTER_ALPHA_RESET;
         cfg_ff.hold_limit    <= HOLD_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/pbel_lowpass.sv =====
// first-order low-pass update of one wheel speed with slow-speed flag
`default_nettype none

module pbel_lowpass
   import pbel_pkg::*;
(
   input  wire logic signed [FILT_WIDTH-1:0]  filt,
   input  wire logic signed [SPEED_WIDTH-1:0] speed,
   input  wire logic [ALPHA_WIDTH-1:0]        alpha,
   input  wire logic [THR_WIDTH-1:0]          min_speed,
   output logic signed [FILT_WIDTH-1:0]       filt_next,
   output logic                               slow
);

   logic signed [FILT_WIDTH-1:0]                target;
   logic signed [FILT_WIDTH:0]                  diff;
   logic signed [ALPHA_WIDTH+FILT_WIDTH+1:0]    prod;
   logic [FILT_WIDTH:0]                         mag;
   logic [FILT_WIDTH:0]                         thr;

   assign target = $signed({speed, {FRAC_BITS{1'b0}}});
   assign diff   = $signed({target[FILT_WIDTH-1], target}) - $signed({filt[FILT_WIDTH-1], filt});
   assign prod   = $signed({1'b0, alpha}) * diff;

   // arithmetic shift by the fraction bits rounds toward minus infinity
   assign filt_next = filt + prod[FILT_WIDTH+FRAC_BITS-1:FRAC_BITS];

   assign mag = filt_next[FILT_WIDTH-1] ? (FILT_WIDTH+1)'(-$signed({1'b1, filt_next}))
                                        : {1'b0, filt_next};
   assign thr  = {{(FILT_WIDTH+1-THR_WIDTH-FRAC_BITS){1'b0}}, min_speed, {FRAC_BITS{1'b0}}};
   assign slow = mag < thr;

endmodule

`default_nettype wire

// ===== design/parking_brake_engage_logic_unit.sv =====
// top level of the parking brake engage logic
// a req transfer is registered in stage 1, then in the result stage driving rsp valid
// throughput: one item per cycle unless rsp stalls; filters and hold count step per item
// a stalled rsp holds the result and the stage before it, back-pressure reaches req ready
// reset: synchronous; config to defaults, filters and lock cleared, hold counter to 51
`default_nettype none

module parking_brake_engage_logic_unit
   import pbel_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   pbel_req_if.sink                        req_chan,
   pbel_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]       csr_wdata
);

   cfg_type cfg;

   logic                          s1_valid_ff;
   logic signed [SPEED_WIDTH-1:0] lin_ff;
   logic signed [SPEED_WIDTH-1:0] ang_ff;
   logic signed [SPEED_WIDTH-1:0] spd_left_ff;
   logic signed [SPEED_WIDTH-1:0] spd_right_ff;
   logic                          fwd_blocked_ff;
   logic                          estop_ff;

   logic signed [FILT_WIDTH-1:0]  filt_left_ff;
   logic signed [FILT_WIDTH-1:0]  filt_left_in;
   logic signed [FILT_WIDTH-1:0]  filt_right_ff;
   logic signed [FILT_WIDTH-1:0]  filt_right_in;
   logic [COUNT_WIDTH-1:0]        hold_count_ff;
   logic [COUNT_WIDTH-1:0]        hold_count_in;
   logic                          lock_held_ff;
   logic                          lock_held_in;

   logic                          rsp_valid_ff;
   logic                          brake_ff;
   logic                          brake_in;
   logic                          braking_in;
   logic                          braking_ff;

   logic                          advance;
   logic                          slow_left;
   logic                          slow_right;
   logic [SPEED_WIDTH:0]          abs_lin;
   logic [SPEED_WIDTH:0]          abs_ang;
   logic [SPEED_WIDTH+1:0]        cmd_sum;
   logic                          driving;
   logic                          reversing;
   logic                          fwd_stop;
   logic signed [SPEED_WIDTH:0]   neg_thr;

   pbel_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbel_lowpass u_lp_left (
      .filt      (filt_left_ff),
      .speed     (spd_left_ff),
      .alpha     (cfg.filter_alpha),
      .min_speed (cfg.lin_speed_thr),
      .filt_next (filt_left_in),
      .slow      (slow_left)
   );

   pbel_lowpass u_lp_right (
      .filt      (filt_right_ff),
      .speed     (spd_right_ff),
      .alpha     (cfg.filter_alpha),
      .min_speed (cfg.lin_speed_thr),
      .filt_next (filt_right_in),
      .slow      (slow_right)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;

   assign abs_lin = lin_ff[SPEED_WIDTH-1] ? (SPEED_WIDTH+1)'(-$signed({1'b1, lin_ff}))
                                          : {1'b0, lin_ff};
   assign abs_ang = ang_ff[SPEED_WIDTH-1] ? (SPEED_WIDTH+1)'(-$signed({1'b1, ang_ff}))
                                          : {1'b0, ang_ff};
   assign cmd_sum = {1'b0, abs_lin} + {1'b0, abs_ang};
   assign driving = cmd_sum >= {{(SPEED_WIDTH+2-THR_WIDTH){1'b0}}, cfg.lin_speed_thr};

   assign neg_thr   = -$signed({{(SPEED_WIDTH+1-THR_WIDTH){1'b0}}, cfg.lin_speed_thr});
   assign reversing = $signed({lin_ff[SPEED_WIDTH-1], lin_ff}) < neg_thr;
   assign fwd_stop  = fwd_blocked_ff && !reversing &&
                      (abs_ang < {{(SPEED_WIDTH+1-THR_WIDTH){1'b0}}, cfg.ang_speed_thr});

   always_comb begin
      hold_count_in = hold_count_ff;
      lock_held_in  = lock_held_ff;
      brake_in      = 1'b1;
      braking_in    = 1'b1;
      if (driving) begin
         hold_count_in = '0;
         lock_held_in  = 1'b0;
         brake_in      = 1'b0;
         braking_in    = 1'b0;
      end else if (hold_count_ff > cfg.hold_limit) begin
         lock_held_in = 1'b1;
      end else if (slow_left || slow_right) begin
         hold_count_in = HOLD_JUMP_VALUE;
      end else if (hold_count_ff != HOLD_COUNT_MAX) begin
         hold_count_in = hold_count_ff + 1'b1;
      end
      // overrides: forward block without reverse or turn, emergency stop
      if (fwd_stop || estop_ff) begin
         lock_held_in = 1'b1;
         brake_in     = 1'b1;
         braking_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         filt_left_ff  <= '0;
         filt_right_ff <= '0;
         hold_count_ff <= HOLD_COUNT_RESET;
         lock_held_ff  <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               filt_left_ff  <= filt_left_in;
               filt_right_ff <= filt_right_in;
               hold_count_ff <= hold_count_in;
               lock_held_ff  <= lock_held_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         lin_ff         <= req_chan.goal_linear;
         ang_ff         <= req_chan.goal_angular;
         spd_left_ff    <= req_chan.speed_left;
         spd_right_ff   <= req_chan.speed_right;
         fwd_blocked_ff <= req_chan.forward_blocked;
         estop_ff       <= req_chan.emergency_stop;
      end
      if (advance && s1_valid_ff) begin
         brake_ff   <= brake_in;
         braking_ff <= braking_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.brake_on = brake_ff;
   assign rsp_chan.lock_on  = lock_held_ff;
   assign rsp_chan.braking  = braking_ff;

endmodule

`default_nettype wire
